// ===== src/olirf_pkg.sv =====
// package for the ordered key list: port widths, default sizes, opcodes and status codes
// no dependencies; imported by olirf_ram and ordered_list_insert_remove_find
`timescale 1ns / 1ps

package olirf_pkg;

    // default sizing of the list store
    localparam int DEPTH_DEF    = 64;
    localparam int KEY_BITS_DEF = 64;

    // fixed port widths
    localparam int OPCODE_W = 3;
    localparam int KEY_W    = 64;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 2;
    localparam int RPOS_W   = 6;
    localparam int COUNT_W  = 7;

    typedef enum logic [OPCODE_W-1:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_REMOVE = 3'd2,
        OP_FIND   = 3'd3,
        OP_CLEAR  = 3'd4
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_BADPOS   = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

endpackage

// ===== src/olirf_ram.sv =====
// list store: single-port-write, single-port-read synchronous memory, registered read
// depends on olirf_pkg for default sizes
`timescale 1ns / 1ps

module olirf_ram
    import olirf_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF,
    localparam int IDX_W   = $clog2(DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [IDX_W-1:0]    i_waddr,
    input  logic [KEY_BITS-1:0] i_wdata,
    input  logic [IDX_W-1:0]    i_raddr,
    output logic [KEY_BITS-1:0] o_rdata
);

    logic [KEY_BITS-1:0] r_mem [DEPTH];
    logic [KEY_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/ordered_list_insert_remove_find.sv =====
// ordered key list: request sequencer around one synchronous list store
// depends on olirf_pkg and olirf_ram
`timescale 1ns / 1ps

// Ordered list of up to DEPTH keys (low KEY_BITS bits of i_key) held in one
// synchronous memory with a registered read. One request word is taken at a time;
// o_stall stays high from acceptance until the result word has been loaded into
// the output register, and that register lets the next request in while a result
// still waits downstream. Append, clear and unused opcodes go from acceptance
// straight to the result state. Find walks the store one entry a cycle from index 0
// until the first match or the end of the list. Remove does the scan and then
// moves each later entry down by one. Insert moves the entries from the end
// down to the target position up by one, one per cycle, and then writes the key.
// The single memory read port, one entry per cycle, paces both the scans and
// the moves. The store needs no clearing after reset: only entries below the
// count are ever read.
module ordered_list_insert_remove_find
    import olirf_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [KEY_W-1:0]    i_key,
    input  logic [POS_W-1:0]    i_position,
    // result channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [RPOS_W-1:0]   o_result_position,
    output logic [COUNT_W-1:0]  o_entry_count
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    // common width for comparing the requested position with the count
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_SHUP = 6'b000100,
        S_SHDN = 6'b001000,
        S_PUT  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [IDX_W-1:0]    r_idx, n_idx;
    t_opcode             r_op, n_op;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [IDX_W-1:0]    r_pos, n_pos;
    t_status             r_res_status, n_res_status;
    logic [IDX_W-1:0]    r_res_pos, n_res_pos;
    logic                r_out_vld, n_out_vld;
    t_status             r_out_status, n_out_status;
    logic [IDX_W-1:0]    r_out_pos, n_out_pos;
    logic [CNT_W-1:0]    r_out_count, n_out_count;

    // memory port
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [KEY_BITS-1:0] ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    logic [KEY_BITS-1:0] ram_rdata;

    logic [KEY_BITS-1:0] in_key;
    logic [IDX_W-1:0]    in_pos;
    logic                full;
    logic                pos_bad;
    logic                hit;
    logic [CNT_W-1:0]    idx_p1;
    logic [CNT_W-1:0]    idx_p2;

    assign in_key  = i_key[KEY_BITS-1:0];
    assign in_pos  = IDX_W'(i_position);
    assign full    = (r_count == CNT_W'(DEPTH));
    assign pos_bad = (CMP_W'(i_position) > CMP_W'(r_count));
    // scan compare against the entry read in the previous cycle
    assign hit     = (ram_rdata == r_key);
    assign idx_p1  = CNT_W'(r_idx) + CNT_W'(1);
    assign idx_p2  = CNT_W'(r_idx) + CNT_W'(2);

    olirf_ram #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_op         = r_op;
        n_key        = r_key;
        n_pos        = r_pos;
        n_res_status = r_res_status;
        n_res_pos    = r_res_pos;
        // output word drops once taken
        n_out_vld    = r_out_vld & i_stall;
        n_out_status = r_out_status;
        n_out_pos    = r_out_pos;
        n_out_count  = r_out_count;
        ram_we       = 1'b0;
        ram_waddr    = r_idx;
        ram_wdata    = ram_rdata;
        ram_raddr    = '0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op         = t_opcode'(i_opcode);
                    n_key        = in_key;
                    n_pos        = in_pos;
                    n_res_status = ST_OK;
                    n_res_pos    = '0;
                    n_state      = S_DONE;
                    case (t_opcode'(i_opcode))
                        OP_APPEND: begin
                            if (full) begin
                                n_res_status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = IDX_W'(r_count);
                                ram_wdata = in_key;
                                n_res_pos = IDX_W'(r_count);
                                n_count   = r_count + CNT_W'(1);
                            end
                        end
                        OP_INSERT: begin
                            if (pos_bad) begin
                                n_res_status = ST_BADPOS;
                            end else if (full) begin
                                n_res_status = ST_FULL;
                            end else if (CMP_W'(i_position) == CMP_W'(r_count)) begin
                                // insert at the end: nothing to move
                                ram_we    = 1'b1;
                                ram_waddr = in_pos;
                                ram_wdata = in_key;
                                n_res_pos = in_pos;
                                n_count   = r_count + CNT_W'(1);
                            end else begin
                                // start moving the tail up from the last entry
                                ram_raddr = IDX_W'(r_count - CNT_W'(1));
                                n_idx     = IDX_W'(r_count);
                                n_res_pos = in_pos;
                                n_state   = S_SHUP;
                            end
                        end
                        OP_REMOVE, OP_FIND: begin
                            if (r_count == '0) begin
                                n_res_status = ST_NOTFOUND;
                            end else begin
                                ram_raddr = '0;
                                n_idx     = '0;
                                n_state   = S_SCAN;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (hit) begin
                    n_res_pos = r_idx;
                    if (r_op == OP_REMOVE) begin
                        if (idx_p1 < r_count) begin
                            // close the gap: fetch the entry above the match
                            ram_raddr = IDX_W'(idx_p1);
                            n_state   = S_SHDN;
                        end else begin
                            n_count = r_count - CNT_W'(1);
                            n_state = S_DONE;
                        end
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (idx_p1 < r_count) begin
                    ram_raddr = IDX_W'(idx_p1);
                    n_idx     = IDX_W'(idx_p1);
                end else begin
                    n_res_status = ST_NOTFOUND;
                    n_state      = S_DONE;
                end
            end

            S_SHDN: begin
                // read data is entry idx+1, moved down to idx
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = ram_rdata;
                if (idx_p2 < r_count) begin
                    ram_raddr = IDX_W'(idx_p2);
                    n_idx     = IDX_W'(idx_p1);
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_DONE;
                end
            end

            S_SHUP: begin
                // read data is entry idx-1, moved up to idx
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = ram_rdata;
                if ((r_idx - IDX_W'(1)) == r_pos) begin
                    n_state = S_PUT;
                end else begin
                    ram_raddr = r_idx - IDX_W'(2);
                    n_idx     = r_idx - IDX_W'(1);
                end
            end

            S_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos;
                ram_wdata = r_key;
                n_count   = r_count + CNT_W'(1);
                n_state   = S_DONE;
            end

            S_DONE: begin
                if (!r_out_vld || !i_stall) begin
                    n_out_vld    = 1'b1;
                    n_out_status = r_res_status;
                    n_out_pos    = r_res_pos;
                    n_out_count  = r_count;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_op         <= n_op;
        r_key        <= n_key;
        r_pos        <= n_pos;
        r_res_status <= n_res_status;
        r_res_pos    <= n_res_pos;
        r_out_status <= n_out_status;
        r_out_pos    <= n_out_pos;
        r_out_count  <= n_out_count;
    end

    assign o_stall           = (r_state != S_IDLE);
    assign o_valid           = r_out_vld;
    assign o_status          = r_out_status;
    assign o_result_position = RPOS_W'(r_out_pos);
    assign o_entry_count     = COUNT_W'(r_out_count);

endmodule

// ===== tb/olirf_list_check.sv =====
// result checker for the ordered key list: mirrors the list and compares every result word
// depends on olirf_pkg; instantiated beside the block by tb_top
`timescale 1ns / 1ps

module olirf_list_check
    import olirf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  logic                i_req_stall,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [KEY_W-1:0]    i_key,
    input  logic [POS_W-1:0]    i_position,
    input  logic                i_res_valid,
    input  logic                i_res_stall,
    input  logic [STATUS_W-1:0] i_status,
    input  logic [RPOS_W-1:0]   i_result_position,
    input  logic [COUNT_W-1:0]  i_entry_count,
    output int                  o_fail_count,
    output int                  o_pending
);

    localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS_DEF);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [RPOS_W-1:0]   rpos;
        logic [COUNT_W-1:0]  count;
    } t_reply;

    logic [KEY_W-1:0] list_keys [DEPTH_DEF];
    int unsigned      list_len = 0;
    t_reply           replies_due [$];
    t_reply           want;
    t_reply           got;
    int               fails = 0;

    // applies one request word to the mirrored list and returns the reply it must give
    function automatic t_reply apply_to_list(input logic [OPCODE_W-1:0] op,
                                             input logic [KEY_W-1:0] key_in,
                                             input logic [POS_W-1:0] pos);
        logic [KEY_W-1:0] k;
        int unsigned      hit;
        t_reply           r;
        k = key_in & KEY_MASK;
        r.status = ST_OK;
        r.rpos = '0;
        hit = DEPTH_DEF;
        // lowest matching index, for remove and find
        for (int unsigned i = 0; i < list_len; i++) begin
            if (hit == DEPTH_DEF && list_keys[i] == k)
                hit = i;
        end
        case (op)
            OP_APPEND: begin
                if (list_len >= DEPTH_DEF) begin
                    r.status = ST_FULL;
                end else begin
                    r.rpos = RPOS_W'(list_len);
                    list_keys[list_len] = k;
                    list_len++;
                end
            end
            OP_INSERT: begin
                if (pos > list_len) begin
                    r.status = ST_BADPOS;
                end else if (list_len >= DEPTH_DEF) begin
                    r.status = ST_FULL;
                end else begin
                    for (int unsigned i = list_len; i > pos; i--)
                        list_keys[i] = list_keys[i-1];
                    list_keys[pos] = k;
                    list_len++;
                    r.rpos = RPOS_W'(pos);
                end
            end
            OP_REMOVE: begin
                if (hit >= DEPTH_DEF) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    r.rpos = RPOS_W'(hit);
                    for (int unsigned i = hit; i + 1 < list_len; i++)
                        list_keys[i] = list_keys[i+1];
                    list_len--;
                end
            end
            OP_FIND: begin
                if (hit >= DEPTH_DEF)
                    r.status = ST_NOTFOUND;
                else
                    r.rpos = RPOS_W'(hit);
            end
            OP_CLEAR: list_len = 0;
            default: ;
        endcase
        r.count = COUNT_W'(list_len);
        return r;
    endfunction

    task automatic compare_field(input string what, input logic [7:0] exp_val,
                                 input logic [7:0] act_val);
        if (act_val !== exp_val) begin
            fails++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, what, exp_val, act_val);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            list_len = 0;
            replies_due.delete();
        end else begin
            // a result word can never come in the cycle its request is taken
            if (i_res_valid && !i_res_stall) begin
                got = '{i_status, i_result_position, i_entry_count};
                if (replies_due.size() == 0) begin
                    fails++;
                    $display("%0t: result word with nothing due, expected none, actual %0d/%0d/%0d",
                             $time, got.status, got.rpos, got.count);
                end else begin
                    want = replies_due.pop_front();
                    compare_field("status", 8'(want.status), 8'(got.status));
                    compare_field("result position", 8'(want.rpos), 8'(got.rpos));
                    compare_field("entry count", 8'(want.count), 8'(got.count));
                end
            end
            if (i_req_valid && !i_req_stall)
                replies_due.insert(replies_due.size(),
                                   apply_to_list(i_opcode, i_key, i_position));
        end
        o_pending    <= replies_due.size();
        o_fail_count <= fails;
    end

endmodule

// ===== tb/tb_top.sv =====
// top of the ordered key list testbench: clock, reset, request stimulus and result stalls
// depends on olirf_pkg, ordered_list_insert_remove_find and olirf_list_check
`timescale 1ns / 1ps

module tb_top;
    import olirf_pkg::*;

    // run shape
    localparam int N_RANDOM       = 1930;
    localparam int IDLE_PCT       = 29;
    localparam int CALM_FROM      = 1100;   // words in this range move with no idling
    localparam int CALM_TO        = 1400;
    localparam int HOLD_AT        = 700;    // result word after which the receiver holds off
    localparam int HOLD_CYCLES    = 400;
    // the result hold-off dominates the quiet time
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 3 * (DEPTH_DEF + 3);

    // opcodes the block leaves alone
    localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

    // episode flavours for the random part
    localparam int MODE_GROW  = 0;
    localparam int MODE_CHURN = 1;
    localparam int MODE_DRAIN = 2;

    localparam logic [KEY_W-1:0] KEY_ZERO = 64'h0;
    localparam logic [KEY_W-1:0] KEY_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [KEY_W-1:0] KEY_MSB  = 64'h8000_0000_0000_0000;
    localparam logic [KEY_W-1:0] KEY_ALT5 = 64'h5555_5555_5555_5555;
    localparam logic [KEY_W-1:0] KEY_ALTA = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam logic [KEY_W-1:0] KEY_MISS = 64'h0000_0000_0000_1234;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [KEY_W-1:0]    key;
        logic [POS_W-1:0]    pos;
    } t_request;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                req_valid    = 1'b0;
    logic                req_stall;
    logic [OPCODE_W-1:0] req_opcode   = '0;
    logic [KEY_W-1:0]    req_key      = '0;
    logic [POS_W-1:0]    req_position = '0;
    logic                res_valid;
    logic                res_stall    = 1'b0;
    logic [STATUS_W-1:0] res_status;
    logic [RPOS_W-1:0]   res_position;
    logic [COUNT_W-1:0]  res_count;
    int                  fail_count;
    int                  pending;

    // list as the stimulus sees it, so that insert positions and lookups can be aimed
    logic [KEY_W-1:0] stim_list [$];
    int               sent_total   = 0;
    int               op_tally [8] = '{default: 0};
    int               full_hits    = 0;
    int               bad_pos_hits = 0;
    int               lookup_misses = 0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    ordered_list_insert_remove_find dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_valid           (req_valid),
        .o_stall           (req_stall),
        .i_opcode          (req_opcode),
        .i_key             (req_key),
        .i_position        (req_position),
        .o_valid           (res_valid),
        .i_stall           (res_stall),
        .o_status          (res_status),
        .o_result_position (res_position),
        .o_entry_count     (res_count)
    );

    olirf_list_check checker_inst (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_req_valid       (req_valid),
        .i_req_stall       (req_stall),
        .i_opcode          (req_opcode),
        .i_key             (req_key),
        .i_position        (req_position),
        .i_res_valid       (res_valid),
        .i_res_stall       (res_stall),
        .i_status          (res_status),
        .i_result_position (res_position),
        .i_entry_count     (res_count),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    // a few fixed keys drawn often, so that duplicates turn up
    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        k = {$urandom, $urandom};
        if ($urandom_range(99) < 40) begin
            case ($urandom_range(5))
                0: k = KEY_ZERO;
                1: k = KEY_ONES;
                2: k = KEY_MSB;
                3: k = KEY_ALT5;
                4: k = KEY_ALTA;
                default: k = 64'h1;
            endcase
        end
        return k;
    endfunction

    // key for remove or find: usually one that is held, so the scan gets somewhere
    function automatic logic [KEY_W-1:0] pick_lookup();
        if (stim_list.size() > 0 && $urandom_range(99) < 75)
            return stim_list[$urandom_range(stim_list.size() - 1)];
        return pick_key();
    endfunction

    // legal insert position, leaning towards the two ends now and then
    function automatic logic [POS_W-1:0] legal_pos();
        int unsigned n;
        n = stim_list.size();
        case ($urandom_range(5))
            0: return '0;
            1: return POS_W'(n);
            default: return POS_W'($urandom_range(n, 0));
        endcase
    endfunction

    function automatic t_request random_request(input int mode);
        t_request    r;
        int unsigned roll;
        roll  = $urandom_range(99);
        r.op  = OP_FIND;
        r.key = pick_lookup();
        // position bits toggle even where the opcode ignores them
        r.pos = POS_W'($urandom);
        case (mode)
            MODE_GROW: begin
                if (roll < 45) begin
                    r.op = OP_APPEND;
                    r.key = pick_key();
                end else if (roll < 90) begin
                    r.op = OP_INSERT;
                    r.key = pick_key();
                    r.pos = legal_pos();
                end else if (roll < 94) begin
                    r.op = OP_INSERT;
                    r.pos = POS_W'($urandom_range(127, stim_list.size() + 1));
                end else if (roll >= 97) begin
                    r.op = OP_REMOVE;
                end
            end
            MODE_CHURN: begin
                if (roll < 18) begin
                    r.op = OP_APPEND;
                    r.key = pick_key();
                end else if (roll < 36) begin
                    r.op = OP_INSERT;
                    r.key = pick_key();
                    r.pos = legal_pos();
                end else if (roll < 42) begin
                    r.op = OP_INSERT;
                    r.pos = POS_W'($urandom_range(127, stim_list.size() + 1));
                end else if (roll < 64) begin
                    r.op = OP_REMOVE;
                end else if (roll < 88) begin
                    r.op = OP_FIND;
                end else if (roll < 91) begin
                    r.op = OP_CLEAR;
                end else if (roll < 96) begin
                    r.op = OPCODE_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
                end else begin
                    r.op = OP_APPEND;
                end
            end
            default: begin
                if (roll < 70) begin
                    r.op = OP_REMOVE;
                end else if (roll < 90) begin
                    r.op = OP_FIND;
                end else if (roll < 95) begin
                    r.op = OP_INSERT;
                    r.pos = legal_pos();
                end else begin
                    r.op = OPCODE_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
                end
            end
        endcase
        return r;
    endfunction

    // keeps the stimulus view of the list in step, and counts the corner cases hit
    function automatic void track(input t_request r);
        int hit;
        hit = -1;
        op_tally[r.op]++;
        case (r.op)
            OP_APPEND: begin
                if (stim_list.size() >= DEPTH_DEF)
                    full_hits++;
                else
                    stim_list.insert(stim_list.size(), r.key);
            end
            OP_INSERT: begin
                if (r.pos > stim_list.size())
                    bad_pos_hits++;
                else if (stim_list.size() >= DEPTH_DEF)
                    full_hits++;
                else
                    stim_list.insert(r.pos, r.key);
            end
            OP_REMOVE, OP_FIND: begin
                for (int i = 0; i < stim_list.size(); i++) begin
                    if (hit < 0 && stim_list[i] == r.key)
                        hit = i;
                end
                if (hit < 0)
                    lookup_misses++;
                else if (r.op == OP_REMOVE)
                    stim_list.delete(hit);
            end
            OP_CLEAR: stim_list.delete();
            default: ;
        endcase
    endfunction

    // offers one request word, idling first at random, and returns once it is taken
    task automatic issue(input logic [OPCODE_W-1:0] op, input logic [KEY_W-1:0] key,
                         input logic [POS_W-1:0] pos);
        t_request r;
        r = '{op, key, pos};
        track(r);
        while (!(sent_total >= CALM_FROM && sent_total < CALM_TO)
               && $urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid    <= 1'b1;
        req_opcode   <= op;
        req_key      <= key;
        req_position <= pos;
        @(posedge clk);
        // payload is held while the block stalls
        while (req_stall)
            @(posedge clk);
        sent_total++;
    endtask

    // request side: directed corners, then random episodes, then the verdict
    initial begin
        t_request    r;
        int          mode;
        int unsigned run_len;
        int          random_done;
        random_done = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list: lookups miss, insert past the count is refused
        issue(OP_FIND,   KEY_ONES, 7'd0);
        issue(OP_REMOVE, KEY_ZERO, 7'd0);
        issue(OP_INSERT, KEY_ONES, 7'd1);
        issue(OP_INSERT, KEY_ONES, 7'd0);
        issue(OP_APPEND, KEY_ZERO, 7'd0);
        issue(OP_APPEND, KEY_MSB,  7'd0);
        // duplicate key: find and remove must take the lowest index
        issue(OP_APPEND, KEY_ONES, 7'd0);
        issue(OP_FIND,   KEY_ONES, 7'd0);
        issue(OP_INSERT, KEY_ALT5, 7'd4);
        issue(OP_INSERT, KEY_ALTA, 7'd2);
        issue(OP_INSERT, KEY_ALT5, 7'd127);
        issue(OP_REMOVE, KEY_ONES, 7'd0);
        issue(OP_FIND,   KEY_ONES, 7'd0);
        issue(OP_REMOVE, KEY_MISS, 7'd0);
        issue(OP_FIND,   KEY_ZERO, 7'd0);
        issue(OP_SPARE_LO, KEY_ONES, 7'd127);
        issue(OP_SPARE_LO + 3'd1, KEY_ZERO, 7'd0);
        issue(OP_SPARE_HI, KEY_MSB, 7'd64);
        // after clear the old entries are still in the store but must not match
        issue(OP_CLEAR,  KEY_ZERO, 7'd0);
        issue(OP_FIND,   KEY_ZERO, 7'd0);
        issue(OP_REMOVE, KEY_MSB,  7'd0);
        issue(OP_APPEND, KEY_ZERO, 7'd0);

        // random episodes: growing ones run into the full store, draining ones empty it
        while (random_done < N_RANDOM) begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6: mode = MODE_GROW;
                7, 8, 9, 10, 11, 12, 13, 14: mode = MODE_CHURN;
                default: mode = MODE_DRAIN;
            endcase
            run_len = $urandom_range(120, 20);
            for (int j = 0; j < run_len && random_done < N_RANDOM; j++) begin
                r = random_request(mode);
                issue(r.op, r.key, r.pos);
                if (r.op <= OP_CLEAR)
                    random_done++;
            end
            if ($urandom_range(9) == 0)
                issue(OP_CLEAR, pick_key(), POS_W'($urandom));
        end
        req_valid <= 1'b0;

        // let the checker see the last word before trusting its count
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests: %0d append, %0d insert, %0d remove, %0d find, %0d clear",
                 sent_total, op_tally[OP_APPEND], op_tally[OP_INSERT], op_tally[OP_REMOVE],
                 op_tally[OP_FIND], op_tally[OP_CLEAR]);
        $display("%0d spare opcodes, %0d full-store refusals, %0d bad positions, %0d misses",
                 op_tally[5] + op_tally[6] + op_tally[7], full_hits, bad_pos_hits,
                 lookup_misses);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // result side: random stalls, a calm stretch, and one long hold-off that backs the
    // block up until it stalls its request input
    initial begin
        int taken;
        taken = 0;
        forever begin
            @(posedge clk);
            if (res_valid && !res_stall) begin
                taken++;
                if (taken == HOLD_AT) begin
                    res_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
            end
            if (taken >= CALM_FROM && taken < CALM_TO)
                res_stall <= 1'b0;
            else
                res_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    // ends the run if no word moves on either channel for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (res_valid && !res_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: watchdog, no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
    end

endmodule
